/* src/assert_macros.svh */
// Assertion macros for the checker of the stack arithmetic unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted
`define SAU_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked assertion that also holds while reset is asserted
`define SAU_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* src/sau_pkg.sv */
// Shared constants, codes and controller/datapath interface types of the stack unit.
package sau_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int DATA_WIDTH  = 32;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int DIV_CNT_W   = $clog2(DATA_WIDTH + 1);
	localparam int FUNC_W      = 3;
	localparam int STATUS_W    = 2;
	localparam int VAL_W       = 32;

	// Operation codes
	localparam logic [FUNC_W-1:0] FUNC_PUSH = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_ADD  = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_DIV  = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_MOD  = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_MUL  = 3'd4;

	// Status codes
	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_SHORT   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_DIVZERO = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd3;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic rd;
		logic exec;
		logic push_wr;
		logic add_wr;
		logic mul_ld;
		logic mul_wr;
		logic div_ld;
		logic div_wr;
		logic out_ld;
	} sau_cmd_t;

	// Decoded operation and stack conditions back to the controller
	typedef struct packed {
		logic is_push;
		logic is_add;
		logic is_mul;
		logic is_div;
		logic full;
		logic short_stack;
		logic div_zero;
		logic div_done;
	} sau_stat_t;

endpackage

/* src/sau_div.sv */
// Iterative signed restoring divider, one quotient bit per cycle.
module sau_div (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [sau_pkg::DATA_WIDTH-1:0] dividend,
	input  logic signed [sau_pkg::DATA_WIDTH-1:0] divisor,
	output logic                                  done,
	output logic signed [sau_pkg::DATA_WIDTH-1:0] quo,
	output logic signed [sau_pkg::DATA_WIDTH-1:0] rem
);

	logic [sau_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [sau_pkg::DATA_WIDTH-1:0] quo_q;
	logic [sau_pkg::DATA_WIDTH-1:0] rem_q;
	logic [sau_pkg::DATA_WIDTH-1:0] mb_q;
	logic                           na_q;
	logic                           neg_q;
	logic [sau_pkg::DATA_WIDTH-1:0] ma;
	logic [sau_pkg::DATA_WIDTH-1:0] mb;
	logic [sau_pkg::DATA_WIDTH:0]   shifted;
	logic [sau_pkg::DATA_WIDTH:0]   diff;

	// Take magnitudes of both operands
	assign ma = dividend[sau_pkg::DATA_WIDTH-1] ? -dividend : dividend;
	assign mb = divisor[sau_pkg::DATA_WIDTH-1]  ? -divisor  : divisor;

	// Trial subtract of the divisor from the shifted partial remainder
	assign shifted = {rem_q, quo_q[sau_pkg::DATA_WIDTH-1]};
	assign diff    = shifted - {1'b0, mb_q};

	// Iteration counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= sau_pkg::DIV_CNT_W'(sau_pkg::DATA_WIDTH);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Load operands, then advance one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= ma;
			rem_q <= '0;
			mb_q  <= mb;
			na_q  <= dividend[sau_pkg::DATA_WIDTH-1];
			neg_q <= dividend[sau_pkg::DATA_WIDTH-1] ^ divisor[sau_pkg::DATA_WIDTH-1];
		end else if (cnt_q != '0) begin
			if (!diff[sau_pkg::DATA_WIDTH]) begin
				rem_q <= diff[sau_pkg::DATA_WIDTH-1:0];
				quo_q <= {quo_q[sau_pkg::DATA_WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= shifted[sau_pkg::DATA_WIDTH-1:0];
				quo_q <= {quo_q[sau_pkg::DATA_WIDTH-2:0], 1'b0};
			end
		end
	end

	// Quotient sign from both operands, remainder sign from the dividend
	assign done = (cnt_q == '0);
	assign quo  = neg_q ? -quo_q : quo_q;
	assign rem  = na_q  ? -rem_q : rem_q;

endmodule

/* src/sau_dp.sv */
// Datapath: stack memory, top-of-stack register, adder, multiplier, divider, output word.
module sau_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  sau_pkg::sau_cmd_t                     cmd,
	output sau_pkg::sau_stat_t                    stat,
	input  logic [sau_pkg::FUNC_W-1:0]            func,
	input  logic signed [sau_pkg::VAL_W-1:0]      push_value,
	output logic [sau_pkg::STATUS_W-1:0]          status,
	output logic signed [sau_pkg::VAL_W-1:0]      top_value,
	output logic [sau_pkg::CNT_W-1:0]             depth
);

	// Entries below the top; the top itself lives in tos_q
	logic [sau_pkg::DATA_WIDTH-1:0] mem [sau_pkg::STACK_DEPTH];

	logic [sau_pkg::FUNC_W-1:0]            func_q;
	logic signed [sau_pkg::DATA_WIDTH-1:0] pv_q;
	logic signed [sau_pkg::DATA_WIDTH-1:0] rd_q;
	logic signed [sau_pkg::DATA_WIDTH-1:0] tos_q;
	logic [sau_pkg::CNT_W-1:0]             count_q;
	logic [sau_pkg::STATUS_W-1:0]          st_q;
	logic [sau_pkg::DATA_WIDTH-1:0]        prod_q;
	logic [sau_pkg::STATUS_W-1:0]          out_status_q;
	logic signed [sau_pkg::VAL_W-1:0]      out_top_q;
	logic [sau_pkg::CNT_W-1:0]             out_depth_q;

	logic [sau_pkg::ADDR_W-1:0]            rd_addr;
	logic [sau_pkg::ADDR_W-1:0]            wr_addr;
	logic [sau_pkg::STATUS_W-1:0]          code;
	logic signed [sau_pkg::DATA_WIDTH-1:0] div_quo;
	logic signed [sau_pkg::DATA_WIDTH-1:0] div_rem;
	logic                                  div_done;

	// Decode the held operation and the stack conditions
	always_comb begin
		stat             = '0;
		stat.is_push     = (func_q == sau_pkg::FUNC_PUSH);
		stat.is_add      = (func_q == sau_pkg::FUNC_ADD);
		stat.is_mul      = (func_q == sau_pkg::FUNC_MUL);
		stat.is_div      = (func_q == sau_pkg::FUNC_DIV) || (func_q == sau_pkg::FUNC_MOD);
		stat.full        = (count_q == sau_pkg::CNT_W'(sau_pkg::STACK_DEPTH));
		stat.short_stack = (count_q < sau_pkg::CNT_W'(2));
		stat.div_zero    = (tos_q == '0);
		stat.div_done    = div_done;
	end

	// Pick the status code of the word
	always_comb begin
		code = sau_pkg::STATUS_OK;
		if (stat.is_push && stat.full) begin
			code = sau_pkg::STATUS_FULL;
		end else if ((stat.is_add || stat.is_mul || stat.is_div) && stat.short_stack) begin
			code = sau_pkg::STATUS_SHORT;
		end else if (stat.is_div && stat.div_zero) begin
			code = sau_pkg::STATUS_DIVZERO;
		end
	end

	// Second entry sits at count-2, the old top moves to count-1 on push
	assign rd_addr = sau_pkg::ADDR_W'(count_q - sau_pkg::CNT_W'(2));
	assign wr_addr = sau_pkg::ADDR_W'(count_q - sau_pkg::CNT_W'(1));

	// Stack memory, registered read
	always_ff @(posedge clk) begin
		if (cmd.push_wr && (count_q != '0)) begin
			mem[wr_addr] <= tos_q;
		end
		if (cmd.rd) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Hold the incoming word, status and product
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func;
			pv_q   <= sau_pkg::DATA_WIDTH'(push_value);
		end
		if (cmd.exec) begin
			st_q <= code;
		end
		if (cmd.mul_ld) begin
			prod_q <= sau_pkg::DATA_WIDTH'(rd_q * tos_q);
		end
	end

	// Top of stack: replace on push or on an ALU result
	always_ff @(posedge clk) begin
		if (cmd.push_wr) begin
			tos_q <= pv_q;
		end else if (cmd.add_wr) begin
			tos_q <= rd_q + tos_q;
		end else if (cmd.mul_wr) begin
			tos_q <= prod_q;
		end else if (cmd.div_wr) begin
			tos_q <= (func_q == sau_pkg::FUNC_MOD) ? div_rem : div_quo;
		end
	end

	// Entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.push_wr) begin
			count_q <= count_q + 1'b1;
		end else if (cmd.add_wr || cmd.mul_wr || cmd.div_wr) begin
			count_q <= count_q - 1'b1;
		end
	end

	sau_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_ld),
		.dividend (rd_q),
		.divisor  (tos_q),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	// Output word register
	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			out_status_q <= st_q;
			out_top_q    <= (count_q != '0) ? sau_pkg::VAL_W'(tos_q) : '0;
			out_depth_q  <= count_q;
		end
	end

	assign status    = out_status_q;
	assign top_value = out_top_q;
	assign depth     = out_depth_q;

endmodule

/* src/sau_ctrl.sv */
// Controller state machine: sequences each operation and owns the handshakes.
module sau_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  sau_pkg::sau_stat_t stat,
	output sau_pkg::sau_cmd_t  cmd
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_READ = 6'b000010,
		S_EXEC = 6'b000100,
		S_MUL  = 6'b001000,
		S_DIV  = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || !out_stall;

	// Next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = S_READ;
				end
			end
			S_READ: begin
				cmd.rd    = 1'b1;
				state_nxt = S_EXEC;
			end
			S_EXEC: begin
				cmd.exec  = 1'b1;
				state_nxt = S_DONE;
				if (stat.is_push) begin
					cmd.push_wr = !stat.full;
				end else if (!stat.short_stack) begin
					if (stat.is_add) begin
						cmd.add_wr = 1'b1;
					end else if (stat.is_mul) begin
						cmd.mul_ld = 1'b1;
						state_nxt  = S_MUL;
					end else if (stat.is_div && !stat.div_zero) begin
						cmd.div_ld = 1'b1;
						state_nxt  = S_DIV;
					end
				end
			end
			S_MUL: begin
				cmd.mul_wr = 1'b1;
				state_nxt  = S_DONE;
			end
			S_DIV: begin
				if (stat.div_done) begin
					cmd.div_wr = 1'b1;
					state_nxt  = S_DONE;
				end
			end
			S_DONE: begin
				if (slot_free) begin
					cmd.out_ld = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// State register and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

/* src/stack_arith_unit.sv */
// Top level of the stack arithmetic unit: controller plus datapath.
//
//   channel  direction  handshake            fields
//   in       input      in_valid / in_stall  func, push_value
//   out      output     out_valid / out_stall status, top_value, depth
//
// One word at a time. Push, add and nop pass the read and execute states into the
// output register; multiply adds a product state, divide and modulo wait in a divide
// state on the one-bit-per-cycle divider. The input reopens as the result is loaded.
// A finished word waits in the output register while the next word is accepted.
// Reset clears the entry count and the handshake state; stack memory is not cleared.
// out_stall holds the result word and delays only the end of the following word.
module stack_arith_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [sau_pkg::FUNC_W-1:0]       func,
	input  logic signed [sau_pkg::VAL_W-1:0] push_value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [sau_pkg::STATUS_W-1:0]     status,
	output logic signed [sau_pkg::VAL_W-1:0] top_value,
	output logic [sau_pkg::CNT_W-1:0]        depth
);

	sau_pkg::sau_cmd_t  cmd;
	sau_pkg::sau_stat_t stat;

	sau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	sau_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.func       (func),
		.push_value (push_value),
		.status     (status),
		.top_value  (top_value),
		.depth      (depth)
	);

endmodule

/* src/sau_checker.sv */
// Port-level checker for the stack arithmetic unit and its bind.
`include "assert_macros.svh"

module sau_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic [sau_pkg::FUNC_W-1:0]       func,
	input logic signed [sau_pkg::VAL_W-1:0] push_value,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [sau_pkg::STATUS_W-1:0]     status,
	input logic signed [sau_pkg::VAL_W-1:0] top_value,
	input logic [sau_pkg::CNT_W-1:0]        depth
);

	logic full_ok;
	logic short_ok;

	// A full status needs a full stack, a short status fewer than two entries
	assign full_ok  = !(out_valid && (status == sau_pkg::STATUS_FULL)) ||
			  (depth == sau_pkg::CNT_W'(sau_pkg::STACK_DEPTH));
	assign short_ok = !(out_valid && (status == sau_pkg::STATUS_SHORT)) ||
			  (depth < sau_pkg::CNT_W'(2));

	// A stalled result word holds
	`SAU_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(status) && $stable(top_value) && $stable(depth), "stalled result word changed")

	// One word at a time: an accepted word closes the input side
	`SAU_ASSERT(a_one_at_a_time, in_valid && !in_stall |=> in_stall, "second word accepted while busy")

	// Depth never exceeds the stack size
	`SAU_ASSERT(a_depth_bound, out_valid |-> depth <= sau_pkg::CNT_W'(sau_pkg::STACK_DEPTH), "depth beyond stack size")

	// Full status only with a full stack, short status only with fewer than two entries
	`SAU_ASSERT(a_status_depth, full_ok && short_ok, "status disagrees with depth")

	// An empty stack shows a zero top
	`SAU_ASSERT(a_empty_top, out_valid && (depth == '0) |-> top_value == '0, "empty stack with nonzero top")

endmodule

bind stack_arith_unit sau_checker u_sau_checker (.*);
